// ----- rtl/core/bwlp_pkg.sv -----
// Shared types, formats and filter constants for the 4-pole low-pass filter.
package bwlp_pkg;

    // Field and history formats
    localparam int JOINT_W    = 5;
    localparam int MAX_JOINTS = 2 ** JOINT_W;
    localparam int HIST_LEN   = 4;
    localparam int SAMPLE_W   = 32;
    localparam int Y_W        = 48;
    localparam int FF_W       = 36;
    localparam int INV_W      = 28;
    localparam int COEF_W     = 33;
    localparam int TERM_W     = 52;

    // 1/GAIN in Q48, rounded to nearest
    localparam logic [63:0] INV_GAIN_WIDE =
        (64'd281474976710656000 + 64'd556491607) / 64'd1112983215;
    localparam logic [INV_W-1:0] INV_GAIN_Q48 = INV_GAIN_WIDE[INV_W-1:0];

    // Feedback coefficient magnitudes in Q30, rounded to nearest
    localparam logic [63:0] A0_WIDE =
        (64'd8485559993 * 64'd1048576 + 64'd4882812) / 64'd9765625;
    localparam logic [63:0] A1_WIDE =
        (64'd35335352195 * 64'd1048576 + 64'd4882812) / 64'd9765625;
    localparam logic [63:0] A2_WIDE =
        (64'd55208191366 * 64'd1048576 + 64'd4882812) / 64'd9765625;
    localparam logic [63:0] A3_WIDE =
        (64'd38358255406 * 64'd1048576 + 64'd4882812) / 64'd9765625;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [Y_W-1:0]      yval_t;
    typedef logic signed [TERM_W-1:0]   term_t;

    // One channel's history; index 0 is the oldest entry
    typedef struct packed {
        sample_t [HIST_LEN-1:0] x;
        yval_t   [HIST_LEN-1:0] y;
    } hist_row_t;

    // Coefficient magnitude for feedback tap (tap 0 weights the oldest output)
    function automatic logic [COEF_W-1:0] coef_mag(input logic [1:0] tap);
        logic [COEF_W-1:0] m;
        unique case (tap)
            2'd0:    m = A0_WIDE[COEF_W-1:0];
            2'd1:    m = A1_WIDE[COEF_W-1:0];
            2'd2:    m = A2_WIDE[COEF_W-1:0];
            default: m = A3_WIDE[COEF_W-1:0];
        endcase
        return m;
    endfunction

    // Coefficient sign: taps 0 and 2 are negative
    function automatic logic coef_neg(input logic [1:0] tap);
        return ~tap[0];
    endfunction

endpackage

// ----- rtl/core/bwlp_hist_mem.sv -----
// Per-channel history memory with row valid bits and registered read.
module bwlp_hist_mem #(
    parameter int CHANNELS = 64,
    parameter int ADDR_W   = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output bwlp_pkg::hist_row_t   rd_row,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  bwlp_pkg::hist_row_t   wr_row
);

    bwlp_pkg::hist_row_t mem [CHANNELS];
    bwlp_pkg::hist_row_t rd_data_reg;
    logic [CHANNELS-1:0] row_valid_reg;
    logic                rd_valid_reg;

    // Storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Row valid bits: a row never written reads as zero history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/core/bwlp_ff_term.sv -----
// Feedforward term: tap sum times 1/GAIN, rounded to Q32, two register stages.
module bwlp_ff_term (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [bwlp_pkg::FF_W-1:0]    ff,
    output bwlp_pkg::term_t                     term
);

    localparam int HALF_W = bwlp_pkg::FF_W / 2;
    localparam int PROD_W = HALF_W + bwlp_pkg::INV_W;

    logic [bwlp_pkg::FF_W-1:0] mag;
    logic [PROD_W-1:0]         prod_hi_reg;
    logic [PROD_W-1:0]         prod_lo_reg;
    logic                      neg_reg;
    logic [63:0]               prod;
    logic [63:0]               prod_rnd;
    bwlp_pkg::term_t           r_ext;
    bwlp_pkg::term_t           term_next;
    bwlp_pkg::term_t           term_reg;

    // Stage A: magnitude split into halves, partial products
    assign mag = ff[bwlp_pkg::FF_W-1] ? bwlp_pkg::FF_W'(-ff) : bwlp_pkg::FF_W'(ff);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_hi_reg <= mag[bwlp_pkg::FF_W-1:HALF_W] * bwlp_pkg::INV_GAIN_Q48;
            prod_lo_reg <= mag[HALF_W-1:0] * bwlp_pkg::INV_GAIN_Q48;
            neg_reg     <= ff[bwlp_pkg::FF_W-1];
        end
    end

    // Stage B: recombine, round half away from zero to 32 fraction bits
    always_comb
    begin
        prod      = 64'({prod_hi_reg, {HALF_W{1'b0}}}) + 64'(prod_lo_reg);
        prod_rnd  = prod + 64'h0000_0000_8000_0000;
        r_ext     = bwlp_pkg::TERM_W'(prod_rnd[63:32]);
        term_next = neg_reg ? -r_ext : r_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

// ----- rtl/core/bwlp_fb_term.sv -----
// Feedback term: output history times a Q30 coefficient, two register stages.
module bwlp_fb_term (
    input  logic                               clk,
    input  logic                               en,
    input  bwlp_pkg::yval_t                    y,
    input  logic [bwlp_pkg::COEF_W-1:0]        coef_mag,
    input  logic                               coef_neg,
    output bwlp_pkg::term_t                    term
);

    localparam int HALF_W = bwlp_pkg::Y_W / 2;
    localparam int PROD_W = HALF_W + bwlp_pkg::COEF_W;
    localparam int FULL_W = PROD_W + HALF_W;
    localparam int RES_W  = FULL_W - 30;

    logic [bwlp_pkg::Y_W-1:0] mag;
    logic [PROD_W-1:0]        prod_hi_reg;
    logic [PROD_W-1:0]        prod_lo_reg;
    logic                     neg_reg;
    logic [FULL_W-1:0]        full;
    logic [RES_W-1:0]         r;
    bwlp_pkg::term_t          r_ext;
    bwlp_pkg::term_t          term_next;
    bwlp_pkg::term_t          term_reg;

    // Stage A: magnitude split into 24-bit halves, partial products
    assign mag = y[bwlp_pkg::Y_W-1] ? bwlp_pkg::Y_W'(-y) : bwlp_pkg::Y_W'(y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_hi_reg <= mag[bwlp_pkg::Y_W-1:HALF_W] * coef_mag;
            prod_lo_reg <= mag[HALF_W-1:0] * coef_mag;
            neg_reg     <= y[bwlp_pkg::Y_W-1] ^ coef_neg;
        end
    end

    // Stage B: recombine, round half away from zero, drop 30 fraction bits
    always_comb
    begin
        full      = {prod_hi_reg, {HALF_W{1'b0}}} + FULL_W'(prod_lo_reg)
                    + (FULL_W'(1) << 29);
        r         = full[FULL_W-1:30];
        r_ext     = bwlp_pkg::TERM_W'(r);
        term_next = neg_reg ? -r_ext : r_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

// ----- rtl/core/butterworth_lowpass_4pole_multichannel_unit.sv -----
// Path: an accepted word passes v1_reg to v4_reg, then out_valid_reg drives m_tvalid.
// Throughput: one word per cycle across channels unless m_tready stalls the output;
// a word whose channel is still in the 4-stage pipeline is held off until that item
// writes back. Rate is set by the read-modify-write of each channel's history row.
// Reset: pipeline and output emptied, history row valid bits cleared, so every
// channel starts from an all-zero history with no clearing pass.
module butterworth_lowpass_4pole_multichannel_unit #(
    parameter int JOINTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic [5:0]  s_tuser,   // [4:0] joint, [5] quantity
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] filtered
    output logic [5:0]  m_tuser    // [4:0] out_joint, [5] out_quantity
);

    localparam int CHANNELS = (JOINTS < bwlp_pkg::MAX_JOINTS) ?
                              2 * JOINTS : 2 * bwlp_pkg::MAX_JOINTS;
    localparam int ADDR_W   = $clog2(CHANNELS);
    localparam int CH_W     = bwlp_pkg::JOINT_W + 1;
    localparam int ACC_W    = bwlp_pkg::TERM_W + 3;
    localparam int RND_W    = bwlp_pkg::Y_W + 1;
    localparam int Q16_W    = RND_W - 16;
    localparam logic [7:0] JOINT_LIMIT = 8'(JOINTS);

    typedef struct packed {
        logic [bwlp_pkg::JOINT_W-1:0] joint;
        logic                         quantity;
        logic                         in_range;
    } meta_t;

    function automatic logic [ADDR_W-1:0] chan_of(input meta_t m);
        logic [CH_W-1:0] ch;
        ch = {m.joint, m.quantity};
        return ch[ADDR_W-1:0];
    endfunction

    logic                advance;
    logic                hazard;
    logic                accept;
    meta_t               in_meta;
    logic [ADDR_W-1:0]   in_ch;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    meta_t               meta1_reg, meta2_reg, meta3_reg, meta4_reg;
    bwlp_pkg::sample_t   sample1_reg;
    bwlp_pkg::hist_row_t shift2_reg, shift3_reg, shift4_reg;
    bwlp_pkg::yval_t     acc4_reg;

    logic                out_valid_reg;
    meta_t               out_meta_reg;
    logic [31:0]         out_filtered_reg;

    bwlp_pkg::hist_row_t rd_row;
    bwlp_pkg::hist_row_t shift1;
    bwlp_pkg::hist_row_t wr_row;
    logic                wr_en;

    logic signed [bwlp_pkg::FF_W-1:0] x0e, x1e, x2e, x3e, se, ff;
    bwlp_pkg::term_t     ff_term;
    bwlp_pkg::term_t     fb_term [bwlp_pkg::HIST_LEN];

    logic signed [ACC_W-1:0] acc_sum;
    bwlp_pkg::yval_t     acc_sat;
    logic signed [RND_W-1:0] rnd;
    logic [Q16_W-1:0]    q16;
    logic [31:0]         filtered_next;

    // Input word decode and channel hazard check
    always_comb
    begin
        in_meta.joint    = s_tuser[bwlp_pkg::JOINT_W-1:0];
        in_meta.quantity = s_tuser[bwlp_pkg::JOINT_W];
        in_meta.in_range = 8'(s_tuser[bwlp_pkg::JOINT_W-1:0]) < JOINT_LIMIT;
        in_ch            = chan_of(in_meta);
        hazard = (v1_reg && meta1_reg.in_range && chan_of(meta1_reg) == in_ch)
              || (v2_reg && meta2_reg.in_range && chan_of(meta2_reg) == in_ch)
              || (v3_reg && meta3_reg.in_range && chan_of(meta3_reg) == in_ch)
              || (v4_reg && meta4_reg.in_range && chan_of(meta4_reg) == in_ch);
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance && !hazard;
    assign accept   = s_tvalid && s_tready;

    // Stage valids and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // History read at acceptance, write-back from the last stage
    bwlp_hist_mem #(
        .CHANNELS (CHANNELS),
        .ADDR_W   (ADDR_W)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance),
        .rd_addr (in_ch),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (chan_of(meta4_reg)),
        .wr_row  (wr_row)
    );

    assign wr_en = advance && v4_reg && meta4_reg.in_range;

    always_comb
    begin
        wr_row      = shift4_reg;
        wr_row.y[3] = acc4_reg;
    end

    // Stage 1: feedforward tap sum 1,4,6,4,1 and shifted history row
    always_comb
    begin
        x0e = bwlp_pkg::FF_W'(rd_row.x[0]);
        x1e = bwlp_pkg::FF_W'(rd_row.x[1]);
        x2e = bwlp_pkg::FF_W'(rd_row.x[2]);
        x3e = bwlp_pkg::FF_W'(rd_row.x[3]);
        se  = bwlp_pkg::FF_W'(sample1_reg);
        ff  = x0e + se + ((x1e + x3e) <<< 2) + (x2e <<< 2) + (x2e <<< 1);

        shift1.x[0] = rd_row.x[1];
        shift1.x[1] = rd_row.x[2];
        shift1.x[2] = rd_row.x[3];
        shift1.x[3] = sample1_reg;
        shift1.y[0] = rd_row.y[1];
        shift1.y[1] = rd_row.y[2];
        shift1.y[2] = rd_row.y[3];
        shift1.y[3] = '0;
    end

    // Stages 2 and 3: product terms
    bwlp_ff_term u_ff (
        .clk  (clk),
        .en   (advance),
        .ff   (ff),
        .term (ff_term)
    );

    for (genvar k = 0; k < bwlp_pkg::HIST_LEN; k++)
    begin : g_fb
        bwlp_fb_term u_fb (
            .clk      (clk),
            .en       (advance),
            .y        (rd_row.y[k]),
            .coef_mag (bwlp_pkg::coef_mag(2'(k))),
            .coef_neg (bwlp_pkg::coef_neg(2'(k))),
            .term     (fb_term[k])
        );
    end

    // Stage 3 to 4: sum of five terms, saturated to 48 bits
    always_comb
    begin
        acc_sum = ACC_W'(ff_term) + ACC_W'(fb_term[0]) + ACC_W'(fb_term[1])
                + ACC_W'(fb_term[2]) + ACC_W'(fb_term[3]);
        if (acc_sum[ACC_W-1:bwlp_pkg::Y_W-1] == '0 ||
            acc_sum[ACC_W-1:bwlp_pkg::Y_W-1] == '1)
        begin
            acc_sat = acc_sum[bwlp_pkg::Y_W-1:0];
        end
        else if (acc_sum[ACC_W-1])
        begin
            acc_sat = {1'b1, {(bwlp_pkg::Y_W-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(bwlp_pkg::Y_W-1){1'b1}}};
        end
    end

    // Stage 4 to output: round to Q16 (half up), saturate to 32 bits, zero out-of-range joints
    always_comb
    begin
        rnd = RND_W'(acc4_reg) + RND_W'(32768);
        q16 = rnd[RND_W-1:16];
        if (q16[Q16_W-1] != q16[Q16_W-2])
        begin
            filtered_next = q16[Q16_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            filtered_next = q16[31:0];
        end
        if (!meta4_reg.in_range)
        begin
            filtered_next = '0;
        end
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meta1_reg        <= in_meta;
            sample1_reg      <= s_tdata;
            meta2_reg        <= meta1_reg;
            shift2_reg       <= shift1;
            meta3_reg        <= meta2_reg;
            shift3_reg       <= shift2_reg;
            meta4_reg        <= meta3_reg;
            shift4_reg       <= shift3_reg;
            acc4_reg         <= acc_sat;
            out_meta_reg     <= meta4_reg;
            out_filtered_reg <= filtered_next;
        end
    end

    // Output word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_filtered_reg;
    assign m_tuser  = {out_meta_reg.quantity, out_meta_reg.joint};

endmodule

// ----- test/butterworth_lowpass_4pole_multichannel_unit_tb.sv -----
// Self-checking testbench for the four-pole low-pass filter unit.
`timescale 1ns / 1ps

module butterworth_lowpass_4pole_multichannel_unit_tb;

    localparam int NUM_JOINTS   = 32;
    localparam int CHANNELS     = NUM_JOINTS * 2;
    localparam int RANDOM_ITEMS = 880;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 200000;

    // 1/GAIN in Q48, rounded to nearest
    localparam longint unsigned RECIP_GAIN_Q48 =
        (64'd281474976710656000 + 64'd556491607) / 64'd1112983215;
    localparam longint Y_MAX = 64'sd140737488355327;
    localparam longint Y_MIN = -64'sd140737488355328;

    typedef enum logic {VELOCITY = 1'b0, ACCELERATION = 1'b1} quantity_e;
    typedef enum int {FOCUS_HOLD_MAX, FOCUS_HOLD_MIN, FOCUS_LEVEL, FOCUS_NOISE, FOCUS_SMALL}
        focus_e;

    typedef struct packed {
        logic [4:0]         joint;
        quantity_e          qty;
        logic signed [31:0] filtered;
    } filtered_word_t;

    typedef struct packed {
        logic [4:0]  joint;
        quantity_e   qty;
        logic [31:0] sample;
        logic        known;
        logic [31:0] result;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;   // [31:0] sample
    logic [5:0]  s_tuser  = 6'd0;    // [4:0] joint, [5] quantity
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] filtered
    logic [5:0]  m_tuser;            // [4:0] out_joint, [5] out_quantity

    // Filter state per channel; index 0 is the oldest entry
    int     in_hist  [CHANNELS][4];
    longint out_hist [CHANNELS][4];

    filtered_word_t expected_words[$];
    filtered_word_t oldest;
    int             mismatches  = 0;
    int             cycle_count = 0;
    bit             calm        = 1'b0;

    // Channels that get long, well-formed runs in the random part
    logic [4:0]  focus_joint [3];
    quantity_e   focus_qty   [3];
    focus_e      focus_mode  [3];
    int          focus_left  [3];
    logic [31:0] focus_level [3];

    // Directed words: zeros into fresh channels, extremes, same-channel bursts
    stim_row_t directed_rows [19] = '{
        '{5'd0,  VELOCITY,     32'h0000_0000, 1'b1, 32'h0000_0000},  // fresh channel
        '{5'd31, ACCELERATION, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{5'd31, VELOCITY,     32'h0000_0000, 1'b1, 32'h0000_0000},
        '{5'd0,  ACCELERATION, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{5'd0,  VELOCITY,     32'h7FFF_FFFF, 1'b0, 32'h0},
        '{5'd0,  VELOCITY,     32'h7FFF_FFFF, 1'b0, 32'h0},
        '{5'd0,  VELOCITY,     32'h7FFF_FFFF, 1'b0, 32'h0},
        '{5'd0,  VELOCITY,     32'h7FFF_FFFF, 1'b0, 32'h0},
        '{5'd0,  VELOCITY,     32'h8000_0000, 1'b0, 32'h0},
        '{5'd0,  VELOCITY,     32'h8000_0000, 1'b0, 32'h0},
        '{5'd31, ACCELERATION, 32'h8000_0000, 1'b0, 32'h0},
        '{5'd31, ACCELERATION, 32'h8000_0000, 1'b0, 32'h0},
        '{5'd31, ACCELERATION, 32'h8000_0000, 1'b0, 32'h0},
        '{5'd21, ACCELERATION, 32'h0000_0001, 1'b0, 32'h0},
        '{5'd10, VELOCITY,     32'hFFFF_FFFF, 1'b0, 32'h0},
        '{5'd10, ACCELERATION, 32'h0001_0000, 1'b0, 32'h0},
        '{5'd21, VELOCITY,     32'h5555_5555, 1'b0, 32'h0},
        '{5'd10, VELOCITY,     32'hAAAA_AAAA, 1'b0, 32'h0},
        '{5'd31, ACCELERATION, 32'h7FFF_FFFF, 1'b0, 32'h0}
    };

    butterworth_lowpass_4pole_multichannel_unit #(
        .JOINTS (NUM_JOINTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Feedback coefficients in Q30; the oldest-output tap comes first
    function automatic longint fb_coef(input int tap);
        case (tap)
            0:       return -longint'((64'd8485559993 * 64'd1048576 + 64'd4882812)
                                      / 64'd9765625);
            1:       return longint'((64'd35335352195 * 64'd1048576 + 64'd4882812)
                                     / 64'd9765625);
            2:       return -longint'((64'd55208191366 * 64'd1048576 + 64'd4882812)
                                      / 64'd9765625);
            default: return longint'((64'd38358255406 * 64'd1048576 + 64'd4882812)
                                     / 64'd9765625);
        endcase
    endfunction

    // Feedback product to 32 fractional bits, half away from zero
    function automatic longint fb_term(input longint y, input longint c);
        longint unsigned ym;
        longint unsigned cm;
        logic [127:0]    prod;
        ym   = (y < 0) ? -y : y;
        cm   = (c < 0) ? -c : c;
        prod = (128'(ym) * 128'(cm) + (128'd1 << 29)) >> 30;
        return ((y < 0) != (c < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // Tap sum (16 fractional bits) times 1/GAIN, to 32 fractional bits
    function automatic longint scaled_taps(input longint ff);
        longint unsigned fm;
        logic [127:0]    prod;
        fm   = (ff < 0) ? -ff : ff;
        prod = (128'(fm) * 128'(RECIP_GAIN_Q48) + (128'd1 << 31)) >> 32;
        return (ff < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // Advance one channel by one sample and give the saturated Q15.16 output
    function automatic logic signed [31:0] filter_sample(input logic [4:0] joint,
                                                         input quantity_e qty,
                                                         input logic signed [31:0] s);
        int     ch;
        longint ff;
        longint acc;
        longint t;
        if (int'(joint) >= NUM_JOINTS)
            return 32'sd0;
        ch  = int'(joint) * 2 + int'(qty);
        ff  = longint'(in_hist[ch][0]) + longint'(s)
            + 4 * (longint'(in_hist[ch][1]) + longint'(in_hist[ch][3]))
            + 6 * longint'(in_hist[ch][2]);
        acc = scaled_taps(ff);
        for (int k = 0; k < 4; k++)
            acc += fb_term(out_hist[ch][k], fb_coef(k));
        if (acc > Y_MAX)
            acc = Y_MAX;
        if (acc < Y_MIN)
            acc = Y_MIN;
        for (int k = 0; k < 3; k++)
        begin
            in_hist[ch][k]  = in_hist[ch][k+1];
            out_hist[ch][k] = out_hist[ch][k+1];
        end
        in_hist[ch][3]  = int'(s);
        out_hist[ch][3] = acc;
        // round half up to 16 fractional bits, then clamp to 32 bits
        t = (acc + 64'sd32768) >>> 16;
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t[31:0];
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Offer one word, wait for the handshake, record what should come back
    task automatic send_sample(input logic [4:0] joint, input quantity_e qty,
                               input logic [31:0] sample, input logic known,
                               input logic [31:0] result);
        filtered_word_t w;
        bit             taken;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= {qty, joint};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        w.joint    = joint;
        w.qty      = qty;
        w.filtered = filter_sample(joint, qty, sample);
        if (known)
            w.filtered = result;
        expected_words.push_back(w);
    endtask

    // Next sample of a focus channel's current run
    function automatic logic [31:0] focus_sample(input int f);
        case (focus_mode[f])
            FOCUS_HOLD_MAX: return 32'h7FFF_FFFF;
            FOCUS_HOLD_MIN: return 32'h8000_0000;
            FOCUS_LEVEL:    return focus_level[f];
            FOCUS_NOISE:    return $urandom;
            default:        return $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    // Output side back-pressure
    initial
    begin : sink_pacing
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each word taken from the output against the oldest expectation
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
                flag_mismatch($sformatf("unexpected word joint %0d tdata %h",
                                        m_tuser[4:0], m_tdata));
            else
            begin
                oldest = expected_words.pop_front();
                if (m_tuser[4:0] !== oldest.joint)
                    flag_mismatch($sformatf("joint %0d, wanted %0d",
                                            m_tuser[4:0], oldest.joint));
                if (m_tuser[5] !== oldest.qty)
                    flag_mismatch($sformatf("quantity %0d, wanted %0d on joint %0d",
                                            m_tuser[5], oldest.qty, oldest.joint));
                if (m_tdata !== oldest.filtered)
                    flag_mismatch($sformatf("filtered %h, wanted %h on joint %0d q %0d",
                                            m_tdata, oldest.filtered, oldest.joint,
                                            oldest.qty));
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          f;
        logic [31:0] sample;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].joint, directed_rows[i].qty,
                        directed_rows[i].sample, directed_rows[i].known,
                        directed_rows[i].result);

        for (int k = 0; k < 3; k++)
        begin
            focus_joint[k] = 5'($urandom_range(0, NUM_JOINTS - 1));
            focus_qty[k]   = quantity_e'($urandom_range(0, 1));
            focus_left[k]  = 0;
        end

        // Mostly long runs on a few channels, the rest scattered words
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 9) < 7)
            begin
                f = $urandom_range(0, 2);
                if (focus_left[f] == 0)
                begin
                    focus_mode[f]  = focus_e'($urandom_range(0, 4));
                    focus_level[f] = $urandom;
                    focus_left[f]  = $urandom_range(60, 160);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        focus_joint[f] = 5'($urandom_range(0, NUM_JOINTS - 1));
                        focus_qty[f]   = quantity_e'($urandom_range(0, 1));
                    end
                end
                focus_left[f]--;
                sample = focus_sample(f);
                send_sample(focus_joint[f], focus_qty[f], sample, 1'b0, 32'h0);
            end
            else
                send_sample(5'($urandom_range(0, 31)), quantity_e'($urandom_range(0, 1)),
                            $urandom, 1'b0, 32'h0);
        end

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
